[design/ksd_pkg.sv]
// shared types, constants and helpers for the keyword substitution decoder
`timescale 1ns / 1ps
`default_nettype none

package ksd_pkg;

  localparam int unsigned LETTERS = 26;
  localparam int unsigned POS_W   = 5;
  localparam int unsigned CHAR_W  = 8;

  localparam logic OP_KEY = 1'b0;
  localparam logic OP_MSG = 1'b1;

  localparam logic [CHAR_W-1:0] CHAR_LC_A = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_LC_Z = 8'h7a;
  localparam logic [CHAR_W-1:0] CHAR_UC_A = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_UC_Z = 8'h5a;

  typedef logic [POS_W-1:0] pos_t;

  typedef struct packed {
    logic is_letter;
    logic upper;
    pos_t idx;
  } letter_t;

  typedef struct packed {
    logic en;
    pos_t addr;
    pos_t data;
  } map_wr_t;

  function automatic letter_t classify(input logic [CHAR_W-1:0] c);
    letter_t       r;
    logic [CHAR_W-1:0] diff;
    r    = '0;
    diff = '0;
    if (c >= CHAR_LC_A && c <= CHAR_LC_Z) begin
      diff        = c - CHAR_LC_A;
      r.is_letter = 1'b1;
      r.upper     = 1'b0;
      r.idx       = diff[POS_W-1:0];
    end else if (c >= CHAR_UC_A && c <= CHAR_UC_Z) begin
      diff        = c - CHAR_UC_A;
      r.is_letter = 1'b1;
      r.upper     = 1'b1;
      r.idx       = diff[POS_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[design/ksd_intf.sv]
// valid/ready channel interfaces for the decoder input and result beats
`timescale 1ns / 1ps
`default_nettype none

interface ksd_in_if
  import ksd_pkg::*;
;
  logic              valid;
  logic              ready;
  logic              op;
  logic [CHAR_W-1:0] char_in;

  modport source (output valid, output op, output char_in, input ready);
  modport sink   (input valid, input op, input char_in, output ready);
endinterface

interface ksd_out_if
  import ksd_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_out;
  logic              was_mapped;

  modport source (output valid, output char_out, output was_mapped, input ready);
  modport sink   (input valid, input char_out, input was_mapped, output ready);
endinterface

`default_nettype wire

[design/ksd_map_mem.sv]
// substitution table: one write port, one read port with registered data
`timescale 1ns / 1ps
`default_nettype none

module ksd_map_mem
  import ksd_pkg::*;
(
  input  wire logic    clk_i,
  input  wire map_wr_t wr_i,
  input  wire logic    rd_en_i,
  input  wire pos_t    rd_addr_i,
  output      pos_t    rd_data_o
);

  pos_t mem_q [LETTERS];
  pos_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

[design/ksd_bind_ctrl.sv]
// binding tracker: assigned flags, next free position, table write generation
`timescale 1ns / 1ps
`default_nettype none

module ksd_bind_ctrl
  import ksd_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              accept_i,
  input  wire logic              op_i,
  input  wire logic [CHAR_W-1:0] char_i,
  output      letter_t           letter_o,
  output      logic              hit_o,
  output      map_wr_t           wr_o
);

  logic [LETTERS-1:0] assigned_q, assigned_d;
  pos_t               next_pos_q, next_pos_d;
  letter_t            lt;
  logic               bind_new;

  assign lt       = classify(char_i);
  assign hit_o    = lt.is_letter & assigned_q[lt.idx];
  assign letter_o = lt;
  assign bind_new = accept_i && (op_i == OP_KEY) && lt.is_letter && !assigned_q[lt.idx];

  always_comb begin
    assigned_d = assigned_q;
    next_pos_d = next_pos_q;
    wr_o.en    = bind_new;
    wr_o.addr  = lt.idx;
    wr_o.data  = next_pos_q;
    if (bind_new) begin
      assigned_d[lt.idx] = 1'b1;
      next_pos_d         = next_pos_q + pos_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      assigned_q <= '0;
      next_pos_q <= '0;
    end else begin
      assigned_q <= assigned_d;
      next_pos_q <= next_pos_d;
    end
  end

endmodule

`default_nettype wire

[design/keyword_substitution_decoder_top.sv]
// Keyword substitution decoder, top level.
// Input channel in_i carries one beat per byte: op selects a key byte (builds the
// table) or a message byte (decoded). Output channel out_o carries one beat per
// message byte: the decoded byte and a flag set when a bound letter was replaced.
// Key bytes never give an output beat; a new letter is bound to the next free
// position in the cycle the beat is accepted.
// One input beat is taken per cycle while in_i.ready is high. A message byte reads the
// 26-entry table, whose read port has registered data, so its result passes through
// the read stage into the output register and waits there until out_o takes it.
// A key byte may be followed by a message byte for the same letter in the next
// cycle: the write lands before the read.
// When the receiver holds off, one beat waits in the read stage and one in the
// output register; input ready falls only when both are full and out_o is stalled.
// Reset clears the assigned flags, the position counter and the pipeline valids;
// table entries are not cleared and their data is only used once their letter is bound.
`timescale 1ns / 1ps
`default_nettype none

module keyword_substitution_decoder_top
  import ksd_pkg::*;
(
  input wire logic clk_i,
  input wire logic rst_ni,
  ksd_in_if.sink   in_i,
  ksd_out_if.source out_o
);

  logic              accept;
  letter_t           lt;
  logic              hit;
  map_wr_t           wr;
  pos_t              rd_data;
  logic              rd_en;

  logic              s1_valid_q, s1_valid_d;
  logic [CHAR_W-1:0] s1_char_q;
  logic              s1_hit_q;
  logic              s1_upper_q;
  logic              s1_adv;

  logic              out_valid_q, out_valid_d;
  logic [CHAR_W-1:0] out_char_q, out_char_d;
  logic              out_mapped_q, out_mapped_d;
  logic [CHAR_W-1:0] base;

  assign s1_adv     = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_adv;
  assign accept     = in_i.valid && in_i.ready;
  assign rd_en      = accept && (in_i.op == OP_MSG);

  ksd_bind_ctrl u_bind (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .op_i     (in_i.op),
    .char_i   (in_i.char_in),
    .letter_o (lt),
    .hit_o    (hit),
    .wr_o     (wr)
  );

  ksd_map_mem u_mem (
    .clk_i     (clk_i),
    .wr_i      (wr),
    .rd_en_i   (rd_en),
    .rd_addr_i (lt.idx),
    .rd_data_o (rd_data)
  );

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
    if (rd_en) begin
      s1_valid_d = 1'b1;
    end
  end

  always_comb begin
    base         = s1_upper_q ? CHAR_UC_A : CHAR_LC_A;
    out_valid_d  = out_valid_q;
    out_char_d   = out_char_q;
    out_mapped_d = out_mapped_q;
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (s1_adv) begin
      out_valid_d  = 1'b1;
      out_mapped_d = s1_hit_q;
      out_char_d   = s1_hit_q ? base + {{(CHAR_W-POS_W){1'b0}}, rd_data} : s1_char_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      s1_char_q  <= in_i.char_in;
      s1_hit_q   <= hit;
      s1_upper_q <= lt.upper;
    end
    out_char_q   <= out_char_d;
    out_mapped_q <= out_mapped_d;
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.char_out   = out_char_q;
  assign out_o.was_mapped = out_mapped_q;

endmodule

`default_nettype wire

[design/ksd_chk.sv]
// port-level checker for the decoder, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module ksd_chk
  import ksd_pkg::*;
(
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_ready_i,
  input wire logic              in_op_i,
  input wire logic              out_valid_i,
  input wire logic              out_ready_i,
  input wire logic [CHAR_W-1:0] out_char_i,
  input wire logic              out_mapped_i
);

  logic in_msg_beat;
  logic out_is_letter;

  assign in_msg_beat   = in_valid_i && in_ready_i && (in_op_i == OP_MSG);
  assign out_is_letter = (out_char_i >= CHAR_LC_A && out_char_i <= CHAR_LC_Z) ||
                         (out_char_i >= CHAR_UC_A && out_char_i <= CHAR_UC_Z);

  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_char_i) && $stable(out_mapped_i))
    else $error("result beat changed while stalled");

  a_out_from_msg : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_msg_beat, 2))
    else $error("result beat without a message byte two cycles earlier");

  a_mapped_letter : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_mapped_i |-> out_is_letter)
    else $error("mapped result is not a letter");

  a_reset_quiet : assert property (@(posedge clk_i)
    !$past(rst_ni) |-> !out_valid_i)
    else $error("result beat right after reset");

endmodule

bind keyword_substitution_decoder_top ksd_chk u_ksd_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .in_op_i      (in_i.op),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_char_i   (out_o.char_out),
  .out_mapped_i (out_o.was_mapped)
);

`default_nettype wire
